### rtl/core/pset_pkg.sv
// Shared types and codes for the priority sorted entry table.
// Holds the request and response words, the stored record layout and the
// controller/datapath command and status groups. No dependencies.
package pset_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_REMOVED   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_ID_ZERO   = 3'd4;
   localparam logic [2:0] ST_MATCH     = 3'd5;
   localparam logic [2:0] ST_NO_MATCH  = 3'd6;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  priority_req;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [15:0] duration;
      logic [15:0] target_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] entry_id;
      logic [7:0]  entry_priority;
      logic [4:0]  entry_day;
      logic [3:0]  entry_month;
      logic [11:0] entry_year;
      logic [4:0]  entry_hour;
      logic [5:0]  entry_minute;
      logic [15:0] entry_duration;
      logic [4:0]  stored_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  prio;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [15:0] duration;
   } rec_type;

   typedef struct packed {
      logic load;
      logic init;
      logic read;
      logic eval;
      logic emit_final;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       full;
      logic       id_zero;
      logic       scan_end;
      logic       eval_stop;
      logic       eval_wait;
      logic       out_free;
   } sts_type;

endpackage

### rtl/core/pset_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module pset_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

### rtl/core/pset_dp.sv
// Datapath of the entry table: request register, count, id counter, scan
// index, pending match, record RAM and response register.
// Depends on pset_pkg and pset_ram.
module pset_dp #(
   parameter int CAPACITY = pset_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  pset_pkg::cmd_type cmd,
   output pset_pkg::sts_type sts,
   input  pset_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pset_pkg::rsp_type rsp_word
);
   import pset_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int RW = $bits(rec_type);

   req_type        req_ff, req_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [15:0]    issued_ff, issued_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic           found_ff, found_in;
   logic           pend_valid_ff, pend_valid_in;
   rec_type        pend_ff, pend_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic           ram_wr_en;
   logic [AW-1:0]  ram_wr_addr;
   rec_type        ram_wr_data;
   logic           ram_rd_en;
   logic [AW-1:0]  ram_rd_addr;
   logic [RW-1:0]  ram_rd_data;

   rec_type        rd_rec;
   rec_type        new_rec;
   logic [15:0]    id_inc;
   logic [15:0]    next_id;
   logic [CW-1:0]  idx_m1;
   logic [CW-1:0]  idx_p1;
   logic           is_match;
   logic           is_insert;
   logic           out_free;

   function automatic rsp_type build_rsp(input logic [2:0] st, input logic [15:0] id,
                                         input rec_type r, input logic use_rec,
                                         input logic [4:0] cnt, input logic lst);
      rsp_type w;
      w = '0;
      w.status       = st;
      w.entry_id     = id;
      w.stored_count = cnt;
      w.last         = lst;
      if (use_rec) begin
         w.entry_priority = r.prio;
         w.entry_day      = r.day;
         w.entry_month    = r.month;
         w.entry_year     = r.year;
         w.entry_hour     = r.hour;
         w.entry_minute   = r.minute;
         w.entry_duration = r.duration;
      end
      return w;
   endfunction

   pset_ram #(
      .WIDTH(RW),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en     (ram_rd_en),
      .rd_addr   (ram_rd_addr),
      .rd_data_ff(ram_rd_data)
   );

   assign rd_rec    = rec_type'(ram_rd_data);
   assign id_inc    = issued_ff + 16'd1;
   // Zero is never handed out: wrap to one
   assign next_id   = (id_inc == 16'd0) ? 16'd1 : id_inc;
   assign idx_m1    = idx_ff - 1'b1;
   assign idx_p1    = idx_ff + 1'b1;
   assign is_insert = (req_ff.kind == KIND_INSERT);
   assign is_match  = (rd_rec.day == req_ff.day) && (rd_rec.month == req_ff.month) &&
                      (rd_rec.year == req_ff.year);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      new_rec          = '0;
      new_rec.id       = next_id;
      new_rec.prio     = req_ff.priority_req;
      new_rec.day      = req_ff.day;
      new_rec.month    = req_ff.month;
      new_rec.year     = req_ff.year;
      new_rec.hour     = req_ff.hour;
      new_rec.minute   = req_ff.minute;
      new_rec.duration = req_ff.duration;
   end

   always_comb begin
      sts           = '0;
      sts.kind      = req_ff.kind;
      sts.full      = (count_ff == CW'(CAPACITY));
      sts.id_zero   = (req_ff.target_id == 16'd0);
      sts.scan_end  = is_insert ? (idx_ff == '0) : (idx_ff == count_ff);
      sts.eval_stop = is_insert && (rd_rec.prio < req_ff.priority_req);
      sts.eval_wait = (req_ff.kind == KIND_QUERY) && is_match && pend_valid_ff;
      sts.out_free  = out_free;
   end

   always_comb begin
      req_in        = req_ff;
      count_in      = count_ff;
      issued_in     = issued_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff[AW-1:0];
      ram_wr_data   = new_rec;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_ff[AW-1:0];

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load) begin
         req_in = req_word;
      end

      if (cmd.init) begin
         idx_in        = is_insert ? count_ff : '0;
         found_in      = 1'b0;
         pend_valid_in = 1'b0;
      end

      if (cmd.read) begin
         if (sts.scan_end) begin
            // Insert reached the head: place the new record in slot zero
            if (is_insert) begin
               ram_wr_en = 1'b1;
            end
         end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = is_insert ? idx_m1[AW-1:0] : idx_ff[AW-1:0];
         end
      end

      if (cmd.eval) begin
         case (req_ff.kind)
            KIND_INSERT: begin
               ram_wr_en = 1'b1;
               if (!sts.eval_stop) begin
                  // Shift a record of equal or larger priority value up one slot
                  ram_wr_data = rd_rec;
                  idx_in      = idx_m1;
               end
            end
            KIND_REMOVE: begin
               if (found_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = idx_m1[AW-1:0];
                  ram_wr_data = rd_rec;
               end else if (rd_rec.id == req_ff.target_id) begin
                  found_in = 1'b1;
               end
               idx_in = idx_p1;
            end
            KIND_QUERY: begin
               if (is_match) begin
                  // Hold one match back so the final one can carry last
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = build_rsp(ST_MATCH, pend_ff.id, pend_ff, 1'b1,
                                        5'(count_ff), 1'b0);
                  end
                  pend_in       = rd_rec;
                  pend_valid_in = 1'b1;
               end
               idx_in = idx_p1;
            end
            default: begin
            end
         endcase
      end

      if (cmd.emit_final) begin
         rsp_valid_in = 1'b1;
         case (req_ff.kind)
            KIND_INSERT: begin
               if (sts.full) begin
                  rsp_in = build_rsp(ST_FULL, 16'd0, pend_ff, 1'b0, 5'(count_ff), 1'b1);
               end else begin
                  count_in  = count_ff + 1'b1;
                  issued_in = next_id;
                  rsp_in = build_rsp(ST_INSERTED, next_id, pend_ff, 1'b0,
                                     5'(count_ff + 1'b1), 1'b1);
               end
            end
            KIND_REMOVE: begin
               if (sts.id_zero) begin
                  rsp_in = build_rsp(ST_ID_ZERO, 16'd0, pend_ff, 1'b0, 5'(count_ff), 1'b1);
               end else if (found_ff) begin
                  count_in = count_ff - 1'b1;
                  rsp_in = build_rsp(ST_REMOVED, req_ff.target_id, pend_ff, 1'b0,
                                     5'(count_ff - 1'b1), 1'b1);
               end else begin
                  rsp_in = build_rsp(ST_NOT_FOUND, 16'd0, pend_ff, 1'b0,
                                     5'(count_ff), 1'b1);
               end
            end
            KIND_QUERY: begin
               if (pend_valid_ff) begin
                  rsp_in = build_rsp(ST_MATCH, pend_ff.id, pend_ff, 1'b1, 5'(count_ff), 1'b1);
               end else begin
                  rsp_in = build_rsp(ST_NO_MATCH, 16'd0, pend_ff, 1'b0, 5'(count_ff), 1'b1);
               end
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && rsp_stall;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         issued_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         issued_ff     <= issued_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      req_ff   <= req_in;
      idx_ff   <= idx_in;
      found_ff <= found_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

### rtl/core/pset_ctrl.sv
// Controller state machine of the entry table: sequences accept, the slot
// scan (read then evaluate) and the final response. Depends on pset_pkg.
module pset_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pset_pkg::sts_type sts,
   output pset_pkg::cmd_type cmd
);
   import pset_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_FINAL = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            unique case (sts.kind)
               KIND_INSERT: begin
                  if (sts.full) begin
                     state_in = S_FINAL;
                  end else begin
                     cmd.init = 1'b1;
                     state_in = S_READ;
                  end
               end
               KIND_REMOVE: begin
                  if (sts.id_zero) begin
                     state_in = S_FINAL;
                  end else begin
                     cmd.init = 1'b1;
                     state_in = S_READ;
                  end
               end
               KIND_QUERY: begin
                  cmd.init = 1'b1;
                  state_in = S_READ;
               end
               default: begin
                  // Unused kind: drop silently
                  state_in = S_IDLE;
               end
            endcase
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = sts.scan_end ? S_FINAL : S_EVAL;
         end
         S_EVAL: begin
            // Hold while an earlier match still waits for the response register
            if (!(sts.eval_wait && !sts.out_free)) begin
               cmd.eval = 1'b1;
               state_in = sts.eval_stop ? S_FINAL : S_READ;
            end
         end
         S_FINAL: begin
            if (sts.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/priority_sorted_entry_table_unit.sv
// Priority sorted entry table: one word at a time. After accept and start, each slot
// visited takes a RAM read, then a compare and shift/write. The scan ends at a closing
// read or, for an insert, at the slot where the new record goes; the finish follows.
// A full insert or a remove of id zero goes from start straight to the finish. The next
// word is taken only once the last is issued; the finish and each held-back match wait
// while rsp_stall holds the response register.
// Synchronous active-high reset empties the table and clears the id counter.
// Depends on pset_pkg, pset_ctrl and pset_dp.
module priority_sorted_entry_table_unit #(
   parameter int CAPACITY = pset_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pset_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pset_pkg::rsp_type rsp_word
);
   import pset_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pset_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   pset_dp #(
      .CAPACITY(CAPACITY)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

endmodule

### rtl/core/pset_chk.sv
// Port-level checks for the entry table, bound to the top level.
// Depends on pset_pkg.
module pset_chk #(
   parameter int CAPACITY = pset_pkg::CAPACITY_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pset_pkg::rsp_type rsp_word
);
   import pset_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("response valid or busy right after reset");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_word.stored_count) <= CAPACITY || CAPACITY > 31)
      else $error("stored count beyond capacity");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == ST_INSERTED || rsp_word.status == ST_FULL ||
                    rsp_word.status == ST_REMOVED || rsp_word.status == ST_NOT_FOUND ||
                    rsp_word.status == ST_ID_ZERO || rsp_word.status == ST_NO_MATCH)
      |-> rsp_word.last)
      else $error("single-word response without last");

   a_insert_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ST_INSERTED |-> rsp_word.entry_id != 16'd0)
      else $error("insert handed out id zero");

endmodule

bind priority_sorted_entry_table_unit pset_chk #(
   .CAPACITY(CAPACITY)
) u_pset_chk (
   .clock    (clock),
   .reset    (reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_word (rsp_word)
);

### verif/testbench.sv
// Self-checking bench for priority_sorted_entry_table_unit: random and directed
// insert/remove/query words, a sorted-table predictor and an in-order scoreboard.
// Depends on pset_pkg and the RTL of the table unit.
module testbench;
   import pset_pkg::*;

   localparam int SLOTS = 16;
   localparam longint CYCLE_LIMIT = 2000000;
   localparam int REQ_W = $bits(req_type);

   class table_scoreboard;
      rec_type   recs[$];
      logic [15:0] last_id;
      rsp_type   pending[$];
      int        errors;
      int        reported;

      function new();
         last_id = 0;
         errors = 0;
         reported = 0;
      endfunction

      function rsp_type blank(logic [2:0] st, logic [15:0] id);
         rsp_type r;
         r = '0;
         r.status = st;
         r.entry_id = id;
         r.stored_count = 5'(recs.size());
         r.last = 1'b1;
         return r;
      endfunction

      // note an accepted word and predict what it causes
      function void note_request(req_type q);
         rsp_type r;
         rec_type e;
         int pos;
         int hits;
         if (q.kind == KIND_INSERT) begin
            if (recs.size() >= SLOTS) begin
               pending.push_back(blank(ST_FULL, 16'd0));
               return;
            end
            pos = 0;
            while (pos < recs.size() && q.priority_req > recs[pos].prio) pos++;
            last_id = last_id + 16'd1;
            if (last_id == 16'd0) last_id = 16'd1;
            e.id = last_id;
            e.prio = q.priority_req;
            e.day = q.day;
            e.month = q.month;
            e.year = q.year;
            e.hour = q.hour;
            e.minute = q.minute;
            e.duration = q.duration;
            recs.insert(pos, e);
            pending.push_back(blank(ST_INSERTED, last_id));
         end else if (q.kind == KIND_REMOVE) begin
            if (q.target_id == 16'd0) begin
               pending.push_back(blank(ST_ID_ZERO, 16'd0));
               return;
            end
            for (int i = 0; i < recs.size(); i++) begin
               if (recs[i].id == q.target_id) begin
                  recs.delete(i);
                  pending.push_back(blank(ST_REMOVED, q.target_id));
                  return;
               end
            end
            pending.push_back(blank(ST_NOT_FOUND, 16'd0));
         end else if (q.kind == KIND_QUERY) begin
            hits = 0;
            foreach (recs[i]) begin
               if (recs[i].day == q.day && recs[i].month == q.month
                   && recs[i].year == q.year) begin
                  r = blank(ST_MATCH, recs[i].id);
                  r.last = 1'b0;
                  r.entry_priority = recs[i].prio;
                  r.entry_day = recs[i].day;
                  r.entry_month = recs[i].month;
                  r.entry_year = recs[i].year;
                  r.entry_hour = recs[i].hour;
                  r.entry_minute = recs[i].minute;
                  r.entry_duration = recs[i].duration;
                  pending.push_back(r);
                  hits++;
               end
            end
            if (hits == 0) pending.push_back(blank(ST_NO_MATCH, 16'd0));
            else pending[$].last = 1'b1;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("unexpected response %h", got);
            end
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("mismatch: expected st=%0d id=%0d pr=%0d d=%0d m=%0d y=%0d h=%0d mi=%0d du=%0d n=%0d l=%0b",
                        want.status, want.entry_id, want.entry_priority, want.entry_day,
                        want.entry_month, want.entry_year, want.entry_hour,
                        want.entry_minute, want.entry_duration, want.stored_count,
                        want.last);
               $display("          actual   st=%0d id=%0d pr=%0d d=%0d m=%0d y=%0d h=%0d mi=%0d du=%0d n=%0d l=%0b",
                        got.status, got.entry_id, got.entry_priority, got.entry_day,
                        got.entry_month, got.entry_year, got.entry_hour,
                        got.entry_minute, got.entry_duration, got.stored_count,
                        got.last);
            end
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_word;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_word;

   table_scoreboard board;
   longint cycles;
   bit      calm;        // no idling in the closing part
   bit      hold_off;    // long receiver stall requested

   priority_sorted_entry_table_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      req_valid = 1'b0;
      req_word = '0;
      rsp_stall = 1'b0;
      reset = 1'b1;
      calm = 1'b0;
      hold_off = 1'b0;
      cycles = 0;
      board = new();
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_word);
   end

   // receiver: random stall bursts, or a long hold-off on request
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_off = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 15);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
            n = $urandom_range(1, 15);
            repeat (n) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
      end
   end

   // offer one word, hold it until taken
   task automatic send_word(req_type q);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= q;
      do @(posedge clock); while (req_stall);
      if (q.kind != KIND_UNUSED) board.note_request(q);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   function automatic req_type make_word(logic [1:0] k, logic [7:0] p,
                                          logic [11:0] yr);
      req_type q;
      q = req_type'(REQ_W'({$urandom, $urandom, $urandom}));
      q.kind = k;
      q.priority_req = p;
      q.year = yr;
      // narrow dates so queries hit often
      q.day = 5'($urandom_range(1, 3));
      q.month = 4'($urandom_range(1, 2));
      return q;
   endfunction

   function automatic req_type random_word();
      req_type q;
      int pick;
      pick = $urandom_range(0, 99);
      q = make_word(2'($urandom_range(0, 2)), 8'($urandom_range(0, 7) * 36),
                    12'($urandom_range(2000, 2001)));
      if (pick < 2) q = req_type'(REQ_W'({$urandom, $urandom, $urandom}));
      else if (pick < 6) q.kind = KIND_REMOVE;
      if (q.kind == KIND_REMOVE && pick >= 2) begin
         if (pick < 60 && board.recs.size() > 0)
            q.target_id = board.recs[$urandom_range(0, board.recs.size() - 1)].id;
         else if (pick < 64) q.target_id = 16'd0;
      end
      if ($urandom_range(0, 9) == 0) q.priority_req = 8'($urandom);
      return q;
   endfunction

   initial begin
      req_type q;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table cases, extremes, full table, ties
      send_word(make_word(KIND_QUERY, 8'd0, 12'd0));
      q = make_word(KIND_REMOVE, 8'd0, 12'd0); q.target_id = 16'd0; send_word(q);
      q.target_id = 16'hFFFF; send_word(q);
      for (int i = 0; i < 17; i++) begin
         q = make_word(KIND_INSERT, (i % 3 == 0) ? 8'd255 : 8'(i % 2), 12'd4095);
         if (i == 0) begin
            q.day = 5'd31; q.month = 4'd15; q.hour = 5'd31; q.minute = 6'd63;
            q.duration = 16'hFFFF;
         end
         if (i == 1) begin
            q.day = 5'd0; q.month = 4'd0; q.hour = 5'd0; q.minute = 6'd0;
            q.duration = 16'd0; q.year = 12'd0;
         end
         send_word(q);
      end
      q = make_word(KIND_QUERY, 8'd0, 12'd4095); q.day = 5'd1; q.month = 4'd1;
      send_word(q);
      q.kind = KIND_UNUSED; send_word(q);
      q = make_word(KIND_REMOVE, 8'd0, 12'd0); q.target_id = 16'd1; send_word(q);
      drain();

      // long receiver hold-off while the sender keeps offering
      hold_off = 1'b1;
      for (int i = 0; i < 20; i++) send_word(random_word());
      drain();

      for (int i = 0; i < 270; i++) begin
         if (i == 230) calm = 1'b1;
         send_word(random_word());
      end
      drain();

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

### files.f
rtl/core/pset_pkg.sv
rtl/core/pset_ram.sv
rtl/core/pset_dp.sv
rtl/core/pset_ctrl.sv
rtl/core/priority_sorted_entry_table_unit.sv
rtl/core/pset_chk.sv
verif/testbench.sv
